// ===== hw/rtl/rau_pkg.sv =====
// Shared types, codes and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int unsigned ValueWidthDef = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               less_than;
    logic               equal;
    logic [1:0]         status;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMBINE,
    S_GCD_START,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_CHECK,
    S_OUT
  } state_t;

  // Command to the shared multiplier.
  typedef struct packed {
    logic       start;
    logic [1:0] sel;
  } mul_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Top level: rational arithmetic with GCD reduction under a small sequencer.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall  | in_item_t
//  out_    | output    | out_valid/out_stall | out_item_t
//
// Compare and flagged items, and items whose numerator is zero, skip the GCD and the
// divisions. Every other item runs four cross products through one multiplier, then a
// GCD by Euclid steps on a shared restoring divider, then both final divisions on it.
// There is at least one Euclid step and at most about 3*VW. Reset is synchronous and
// clears the sequencer. in_stall is high while an item is at work. A finished item
// holds until the output register is free.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned DW = 2 * VW;

  state_t state_r, state_nxt;

  // Normalized operands: sign and magnitude.
  logic [VW-1:0] an_r, ad_r, bn_r, bd_r;
  logic          an_neg_r, bn_neg_r;
  op_t           op_r;
  logic [1:0]    msel_r;
  logic [1:0]    mcnt_r;
  logic [DW-1:0] p0_r, p1_r, p2_r; // an*bd, bn*ad, an*bn; ad*bd comes off the multiplier
  logic [DW-1:0] num_r, den_r, ga_r, gb_r;
  logic          num_neg_r;
  out_item_t     res_r;
  out_item_t     out_r;
  logic          out_valid_r;

  logic [VW-1:0] ma, mb;
  logic [DW-1:0] product;
  logic          div_start;
  logic [DW-1:0] div_dvd, div_dsr, div_q, div_r;
  logic          div_busy;

  logic [DW-1:0] lim;
  logic          acc_in, div_done, out_load;
  logic [DW-1:0] t2m;
  logic          t1n, t2n;
  logic          cmp_lt, cmp_eq;
  logic [DW-1:0] sum_mag, cmb_num, cmb_den;
  logic          sum_neg, cmb_neg;
  logic [VW-1:0] v_an, v_ad, v_bn, v_bd;
  logic          zd, badop, early_out;

  function automatic logic [VW-1:0] mag_of(input logic [31:0] raw);
    logic [VW-1:0] v;
    v = raw[VW-1:0];
    return v[VW-1] ? (~v + 1'b1) : v;
  endfunction

  rau_multiplier #(.VW(VW)) u_mul (
    .clk(clk), .op_a(ma), .op_b(mb), .product(product)
  );

  rau_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  always_comb begin
    unique case (msel_r)
      2'd0:    begin ma = an_r; mb = bd_r; end
      2'd1:    begin ma = bn_r; mb = ad_r; end
      2'd2:    begin ma = an_r; mb = bn_r; end
      default: begin ma = ad_r; mb = bd_r; end
    endcase
  end

  assign v_an      = in_item.a_num[VW-1:0];
  assign v_ad      = in_item.a_den[VW-1:0];
  assign v_bn      = in_item.b_num[VW-1:0];
  assign v_bd      = in_item.b_den[VW-1:0];
  assign badop     = in_item.req_type > OP_CMP;
  assign zd        = (v_ad == '0) || (v_bd == '0);
  assign early_out = badop || zd || (in_item.req_type == OP_DIV && v_bn == '0);

  assign lim      = DW'(1) << (VW - 1);
  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign div_done = !div_busy;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign t1n      = an_neg_r;
  assign t2n      = bn_neg_r ^ (op_r == OP_SUB);
  assign t2m      = p1_r;

  always_comb begin
    // Sign-magnitude compare of an*bd against bn*ad.
    if (an_neg_r != bn_neg_r) begin
      cmp_lt = an_neg_r;
      cmp_eq = 1'b0;
    end else begin
      cmp_eq = (p0_r == p1_r);
      cmp_lt = an_neg_r ? (p0_r > p1_r) : (p0_r < p1_r);
    end
    // Signed sum of an*bd and the second term.
    if (t1n == t2n) begin
      sum_mag = p0_r + t2m;
      sum_neg = t1n;
    end else if (p0_r >= t2m) begin
      sum_mag = p0_r - t2m;
      sum_neg = t1n;
    end else begin
      sum_mag = t2m - p0_r;
      sum_neg = t2n;
    end
    unique case (op_r)
      OP_ADD, OP_SUB: begin
        cmb_num = sum_mag;
        cmb_neg = sum_neg;
        cmb_den = product;
      end
      OP_MUL: begin
        cmb_num = p2_r;
        cmb_neg = an_neg_r ^ bn_neg_r;
        cmb_den = product;
      end
      default: begin
        // Divide: den is bn*ad; the sign of b_num goes into the result sign.
        cmb_num = p0_r;
        cmb_neg = an_neg_r ^ bn_neg_r;
        cmb_den = p1_r;
      end
    endcase

    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = ga_r;
    div_dsr   = gb_r;
    unique case (state_r)
      S_IDLE:    if (acc_in) state_nxt = early_out ? S_OUT : S_MUL;
      S_MUL:     if (mcnt_r == 2'd3) state_nxt = S_COMBINE;
      S_COMBINE: state_nxt = (op_r == OP_CMP || cmb_num == '0) ? S_OUT : S_GCD_START;
      S_GCD_START: begin
        if (gb_r == '0) state_nxt = S_DIV_NUM;
        else begin
          div_start = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: if (div_done) state_nxt = S_GCD_START;
      S_DIV_NUM: begin
        div_dvd   = num_r;
        div_dsr   = ga_r;
        div_start = 1'b1;
        state_nxt = S_DIV_DEN;
      end
      S_DIV_DEN: if (div_done) begin
        div_dvd   = den_r;
        div_dsr   = ga_r;
        div_start = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: if (div_done) state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      msel_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (out_load) out_r <= res_r;
      unique case (state_r)
        S_IDLE: if (acc_in) begin
          an_r <= mag_of(in_item.a_num);
          ad_r <= mag_of(in_item.a_den);
          bn_r <= mag_of(in_item.b_num);
          bd_r <= mag_of(in_item.b_den);
          an_neg_r <= (v_an[VW-1] ^ v_ad[VW-1]) && (v_an != '0);
          bn_neg_r <= (v_bn[VW-1] ^ v_bd[VW-1]) && (v_bn != '0);
          op_r <= op_t'(in_item.req_type);
          res_r <= '{res_num: 32'sd0, res_den: 31'd1, less_than: 1'b0, equal: 1'b0,
                     status: (early_out && !badop) ? ST_ZERO_DEN : ST_OK};
          msel_r <= 2'd0;
          mcnt_r <= 2'd0;
        end
        S_MUL: begin
          // The product is registered, so it follows its select in the next cycle.
          msel_r <= msel_r + 2'd1;
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd1) p0_r <= product;
          if (mcnt_r == 2'd2) p1_r <= product;
          if (mcnt_r == 2'd3) p2_r <= product;
        end
        S_COMBINE: begin
          num_r     <= cmb_num;
          num_neg_r <= cmb_neg;
          den_r     <= cmb_den;
          ga_r      <= cmb_num;
          gb_r      <= cmb_den;
          if (op_r == OP_CMP) begin
            res_r.less_than <= cmp_lt;
            res_r.equal     <= cmp_eq;
          end
        end
        S_GCD: if (div_done) begin
          ga_r <= gb_r;
          gb_r <= div_r;
        end
        S_DIV_DEN: if (div_done) num_r <= div_q;
        S_CHECK: if (div_done) begin
          if (div_q > lim - 1'b1 || num_r > (num_neg_r ? lim : lim - 1'b1))
            res_r.status <= ST_OVERFLOW;
          else begin
            res_r.res_num <= 32'(signed'(num_neg_r ? -num_r[VW-1:0] : num_r[VW-1:0]));
            res_r.res_den <= 31'(div_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rau_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, gives quotient and remainder.
`default_nettype none
module rau_divider import rau_pkg::*; #(
  parameter int unsigned W = 2 * ValueWidthDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one dividend bit in, subtract when it fits.
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rau_multiplier.sv =====
// Shared magnitude multiplier, one product per cycle, result registered.
`default_nettype none
module rau_multiplier import rau_pkg::*; #(
  parameter int unsigned VW = ValueWidthDef
) (
  input  wire logic            clk,
  input  wire logic [VW-1:0]   op_a,
  input  wire logic [VW-1:0]   op_b,
  output logic [2*VW-1:0]      product
);

  logic [2*VW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign product = prod_r;

endmodule
`default_nettype wire
